@@ sv/icsum_pkg.sv @@
// Shared types, register codes and ones'-complement helpers for the
// Internet checksum unit. No dependencies.
package icsum_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned AddrW  = 32;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;

	// IP protocol number for UDP, summed into the pseudo-header
	localparam logic [WordW-1:0] ProtoUdp = 16'd17;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_UDP_MODE = 2'd0,
		REG_SRC_ADDR = 2'd1,
		REG_DST_ADDR = 2'd2
	} cfg_reg_t;

	// accumulator result handed to the final stage
	typedef struct packed {
		logic             last;
		logic [WordW-1:0] sum;
		logic [WordW-1:0] count;
	} acc_t;

	// 16-bit ones'-complement add with end-around carry
	function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
			input logic [WordW-1:0] b);
		logic [WordW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
	endfunction

	// fold a 19-bit sum of up to eight words back to 16 bits
	function automatic logic [WordW-1:0] oc_fold(input logic [WordW+2:0] t);
		logic [WordW:0] f;
		f = {1'b0, t[WordW-1:0]} + {{(WordW-2){1'b0}}, t[WordW+2:WordW]};
		return f[WordW-1:0] + {{(WordW-1){1'b0}}, f[WordW]};
	endfunction

endpackage

@@ sv/icsum_if.sv @@
// Handshake channels of the checksum unit: packet words in, checksums out.
// Depends on icsum_pkg.
interface icsum_in_if;
	import icsum_pkg::*;
	logic             valid;
	logic             ready;
	logic [WordW-1:0] data_word;
	logic             odd_tail;
	logic             end_of_packet;

	modport source(output valid, data_word, odd_tail, end_of_packet, input ready);
	modport sink(input valid, data_word, odd_tail, end_of_packet, output ready);
endinterface

interface icsum_out_if;
	import icsum_pkg::*;
	logic             valid;
	logic             ready;
	logic [WordW-1:0] checksum;

	modport source(output valid, checksum, input ready);
	modport sink(input valid, checksum, output ready);
endinterface

@@ sv/internet_checksum_udp_icmp_unit.sv @@
// Top level of the streaming Internet checksum unit: configuration
// registers, pseudo-header sum and output register. Depends on icsum_pkg,
// icsum_if and icsum_acc.

// Takes one 16-bit packet word per cycle and returns the complemented
// ones'-complement checksum through the input register, accumulator stage
// and output register. The sustained rate is one word per clock, set by the
// loop of the running-sum adder, while no finished checksum waits on the
// output side. Words that do not end a packet give no result and never
// need the output side. In UDP mode the IPv4 pseudo-header (addresses,
// protocol 17, byte count) is folded in; mode and addresses are read when
// the last word reaches the final stage, so write them only while idle.
module internet_checksum_udp_icmp_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	icsum_in_if.sink                        data_in,
	icsum_out_if.source                     result,
	input  logic                            wr_en,
	input  logic [icsum_pkg::CfgIdxW-1:0]   wr_index,
	input  logic [icsum_pkg::CfgDataW-1:0]  wr_data
);
	import icsum_pkg::*;

	logic             udp_mode_q;
	logic [AddrW-1:0] src_addr_q;
	logic [AddrW-1:0] dst_addr_q;
	logic             vld_s2;
	acc_t             acc_s2;
	logic             s2_go;
	logic             out_free;
	logic             out_valid_q;
	logic [WordW-1:0] checksum_q;
	logic [WordW+2:0] total;
	logic [WordW-1:0] final_sum;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udp_mode_q <= 1'b0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_UDP_MODE: udp_mode_q <= wr_data[0];
				REG_SRC_ADDR: src_addr_q <= wr_data[AddrW-1:0];
				REG_DST_ADDR: dst_addr_q <= wr_data[AddrW-1:0];
				default: ;
			endcase
		end
	end

	// flow control: non-final words drain without needing the output
	assign out_free = !out_valid_q || result.ready;
	assign s2_go    = !vld_s2 || !acc_s2.last || out_free;

	icsum_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.data_in(data_in),
		.s2_go  (s2_go),
		.vld_s2 (vld_s2),
		.acc_s2 (acc_s2)
	);

	// pseudo-header: seven words summed wide, then folded
	assign total = {3'b000, acc_s2.sum} + {3'b000, acc_s2.count}
		+ {3'b000, src_addr_q[AddrW-1:WordW]} + {3'b000, src_addr_q[WordW-1:0]}
		+ {3'b000, dst_addr_q[AddrW-1:WordW]} + {3'b000, dst_addr_q[WordW-1:0]}
		+ {3'b000, ProtoUdp};
	assign final_sum = udp_mode_q ? oc_fold(total) : acc_s2.sum;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= vld_s2 && acc_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s2 && acc_s2.last) begin
			checksum_q <= ~final_sum;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.checksum = checksum_q;

	// a result appears only after a last word sat in the final stage
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_s2 && acc_s2.last))
		else $error("result without a last word");

	// a UDP sum includes protocol 17, so it is never zero and never complements to 0xFFFF
	a_udp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && acc_s2.last && out_free && udp_mode_q) |=> result.checksum != 16'hFFFF)
		else $error("UDP checksum of an all-zero sum");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> data_in.ready)
		else $error("input stalled with empty output");

endmodule

@@ sv/icsum_acc.sv @@
// Input register and running ones'-complement sum / byte count.
// Depends on icsum_pkg and icsum_in_if.
module icsum_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	icsum_in_if.sink             data_in,
	input  logic                 s2_go,
	output logic                 vld_s2,
	output icsum_pkg::acc_t      acc_s2
);
	import icsum_pkg::*;

	logic             vld_s1;
	logic [WordW-1:0] word_s1;
	logic             odd_s1;
	logic             last_s1;
	logic             s1_go;
	logic [WordW-1:0] sum_q;
	logic [WordW-1:0] count_q;
	logic [WordW-1:0] sum_nxt;
	logic [WordW-1:0] count_nxt;
	logic             in_odd;

	assign s1_go         = !vld_s1 || s2_go;
	assign data_in.ready = s1_go;

	// a lone trailing byte only counts on the last word
	assign in_odd = data_in.end_of_packet && data_in.odd_tail;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_go) begin
			vld_s1 <= data_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			word_s1 <= in_odd ? {data_in.data_word[WordW-1:8], 8'h00} : data_in.data_word;
			odd_s1  <= in_odd;
			last_s1 <= data_in.end_of_packet;
		end
	end

	// running sum and byte count, cleared after the last word
	assign sum_nxt   = oc_add(sum_q, word_s1);
	assign count_nxt = count_q + (odd_s1 ? 16'd1 : 16'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (vld_s1 && s1_go) begin
			sum_q   <= last_s1 ? '0 : sum_nxt;
			count_q <= last_s1 ? '0 : count_nxt;
		end
	end

	// hand-off register to the final stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_go) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			acc_s2.last  <= last_s1;
			acc_s2.sum   <= sum_nxt;
			acc_s2.count <= count_nxt;
		end
	end

endmodule
